// ===== rtl/core/indexed_linked_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Indexed linked list engine assertion macros
// Clocked, reset-gated property wrappers used by the engine's checks.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define ILE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared sizes, codes and control types of the indexed linked list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  // Sizes
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 9;
  localparam int CMD_W    = 4;
  localparam int ERR_W    = 2;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 112;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_REMOVE     = 4'd5,
    CMD_READ_AT    = 4'd6,
    CMD_READ_END   = 4'd7,
    CMD_REVERSE    = 4'd8
  } cmd_e;

  // Error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_INS   = 3'd1,  // open a slot at pos, shift the rest up
    OP_DEL   = 3'd2,  // close the slot at pos, shift the rest down
    OP_LOAD  = 3'd3,  // copy values onto the lane
    OP_SHIFT = 3'd4,  // lane moves one cell toward the front
    OP_REV   = 3'd5   // lane feeds the front while values shift up
  } cell_op_e;

  // Engine sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_LOAD = 3'd1,
    ST_WALK = 3'd2,
    ST_REV  = 3'd3,
    ST_DONE = 3'd4
  } state_e;

  // Control group from sequencer to the cell row
  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  din;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an element value and a lane value that travels
// toward the front of the row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_cell (
  input  wire logic                     clk_i,
  input  wire logic [ile_pkg::IDX_W-1:0] idx_i,
  input  wire ile_pkg::cell_ctl_t       ctl_i,
  input  wire logic [ile_pkg::VAL_W-1:0] val_left_i,
  input  wire logic [ile_pkg::VAL_W-1:0] val_right_i,
  input  wire logic [ile_pkg::VAL_W-1:0] lane_right_i,
  output logic      [ile_pkg::VAL_W-1:0] val_o,
  output logic      [ile_pkg::VAL_W-1:0] lane_o
);
  import ile_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] lane_q, lane_d;
  logic [POS_W-1:0] idx_ext;

  assign idx_ext = POS_W'(idx_i);

  // Next value and lane for the broadcast operation
  always_comb begin
    val_d  = val_q;
    lane_d = lane_q;
    case (ctl_i.op)
      OP_INS: begin
        if (idx_ext > ctl_i.pos) begin
          val_d = val_left_i;
        end else if (idx_ext == ctl_i.pos) begin
          val_d = ctl_i.din;
        end
      end
      OP_DEL: begin
        if (idx_ext >= ctl_i.pos) begin
          val_d = val_right_i;
        end
      end
      OP_LOAD: begin
        lane_d = val_q;
      end
      OP_SHIFT: begin
        lane_d = lane_right_i;
      end
      OP_REV: begin
        val_d  = val_left_i;
        lane_d = lane_right_i;
      end
      default: begin
        val_d  = val_q;
        lane_d = lane_q;
      end
    endcase
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    lane_q <= lane_d;
  end

  assign val_o  = val_q;
  assign lane_o = lane_q;

endmodule

`default_nettype wire

// ===== rtl/core/ile_row.sv =====
// ----------------------------------------------------------------------------
// ile_row
// Row of CAPACITY cells; element k of the list lives in cell k. Neighbors
// pass values up, down and along the lane each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_row (
  input  wire logic                      clk_i,
  input  wire ile_pkg::cell_ctl_t        ctl_i,
  output logic      [ile_pkg::VAL_W-1:0] front_o,
  output logic      [ile_pkg::VAL_W-1:0] lane0_o
);
  import ile_pkg::*;

  logic [VAL_W-1:0] val_w   [CAPACITY];
  logic [VAL_W-1:0] lane_w  [CAPACITY];
  logic [VAL_W-1:0] left_w  [CAPACITY];
  logic [VAL_W-1:0] right_w [CAPACITY];
  logic [VAL_W-1:0] lright_w[CAPACITY];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    // Neighbor wiring; the front cell is fed from its own lane on reverse
    if (k == 0) begin : g_first
      assign left_w[k] = lane_w[0];
    end else begin : g_mid
      assign left_w[k] = val_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w[k]  = '0;
      assign lright_w[k] = '0;
    end else begin : g_inner
      assign right_w[k]  = val_w[k+1];
      assign lright_w[k] = lane_w[k+1];
    end

    ile_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (IDX_W'(k)),
      .ctl_i        (ctl_i),
      .val_left_i   (left_w[k]),
      .val_right_i  (right_w[k]),
      .lane_right_i (lright_w[k]),
      .val_o        (val_w[k]),
      .lane_o       (lane_w[k])
    );
  end

  assign front_o = val_w[0];
  assign lane0_o = lane_w[0];

endmodule

`default_nettype wire

// ===== rtl/core/indexed_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Bounded ordered list with push/pop at both ends, indexed insert, remove
// and read, read from the end, and reverse, kept in a row of cells.
//
//   channel  dir  signals          transaction contents
//   s_axis   in   tvalid/tready    cmd, position, data_in (one command)
//   m_axis   out  tvalid/tready    data_out, error_code, count, empty,
//                                  front and back values (one result)
//
// Errors, unknown codes, push, pop front, insert, remove off the tail and
// reverse of fewer than two go from decode straight to the done state;
// read at p, read from end, pop back and remove at the tail of a longer
// list, and longer reverse load the lane first: it moves one cell per cycle.
// Reset empties the list; cell values are undefined until written.
// A new command is taken while a result waits in the output register; a
// finished result waits in the done state until that register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_linked_list_engine_assert.svh"

module indexed_linked_list_engine (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] cmd, [12:4] position, [44:13] data_in, [47:45] zero
  input  wire logic [ile_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [31:0] data_out, [33:32] error_code, [42:34] element_count,
  // [43] is_empty, [75:44] front_value, [107:76] back_value, [111:108] zero
  output logic      [ile_pkg::OUT_W-1:0] m_axis_tdata
);
  import ile_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [VAL_W-1:0]  back_q, back_d;
  logic [VAL_W-1:0]  dout_q, dout_d;
  err_e              err_q, err_d;
  logic              cap_dout_q, cap_dout_d;
  logic              cap_back_q, cap_back_d;
  logic              rev_q, rev_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_W-1:0]  m_data_q, m_data_d;

  cell_ctl_t         ctl;
  logic [VAL_W-1:0]  front_w;
  logic [VAL_W-1:0]  lane0_w;

  cmd_e              in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_din;
  logic [CNT_W-1:0]  pos_c;
  logic              full;
  logic [VAL_W-1:0]  res_dout;
  logic [VAL_W-1:0]  res_back;
  logic [VAL_W-1:0]  res_front_g;
  logic [VAL_W-1:0]  res_back_g;
  logic              res_empty;

  assign in_cmd = cmd_e'(s_axis_tdata[3:0]);
  assign in_pos = s_axis_tdata[12:4];
  assign in_din = s_axis_tdata[44:13];
  assign pos_c  = CNT_W'(in_pos);
  assign full   = (count_q == CNT_W'(CAPACITY));

  // Cell row
  ile_row u_row (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .front_o (front_w),
    .lane0_o (lane0_w)
  );

  // Result assembly from captured lane value or staged registers
  assign res_dout    = cap_dout_q ? lane0_w : dout_q;
  assign res_back    = cap_back_q ? lane0_w : back_q;
  assign res_empty   = (count_q == '0);
  assign res_front_g = res_empty ? '0 : front_w;
  assign res_back_g  = res_empty ? '0 : res_back;

  // Sequencer: decode, walk, reverse, hand off result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cnt_d      = cnt_q;
    back_d     = back_q;
    dout_d     = dout_q;
    err_d      = err_q;
    cap_dout_d = cap_dout_q;
    cap_back_d = cap_back_q;
    rev_d      = rev_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    ctl.op     = OP_HOLD;
    ctl.pos    = in_pos;
    ctl.din    = in_din;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          dout_d     = '0;
          err_d      = ERR_OK;
          cap_dout_d = 1'b0;
          cap_back_d = 1'b0;
          rev_d      = 1'b0;
          state_d    = ST_DONE;
          case (in_cmd)
            CMD_PUSH_FRONT: begin
              if (full) begin
                err_d = ERR_FULL;
              end else begin
                ctl.op  = OP_INS;
                ctl.pos = '0;
                count_d = count_q + CNT_W'(1);
                if (count_q == '0) begin
                  back_d = in_din;
                end
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                err_d = ERR_FULL;
              end else begin
                ctl.op  = OP_INS;
                ctl.pos = POS_W'(count_q);
                count_d = count_q + CNT_W'(1);
                back_d  = in_din;
              end
            end
            CMD_POP_FRONT: begin
              if (count_q == '0) begin
                err_d = ERR_INDEX;
              end else begin
                dout_d  = front_w;
                ctl.op  = OP_DEL;
                ctl.pos = '0;
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              if (count_q == '0) begin
                err_d = ERR_INDEX;
              end else begin
                dout_d  = back_q;
                count_d = count_q - CNT_W'(1);
                // new tail sits one before the old one
                if (count_q >= CNT_W'(2)) begin
                  cnt_d      = count_q - CNT_W'(2);
                  cap_back_d = 1'b1;
                  state_d    = ST_LOAD;
                end
              end
            end
            CMD_INSERT: begin
              if (pos_c > count_q) begin
                err_d = ERR_INDEX;
              end else if (full) begin
                err_d = ERR_FULL;
              end else begin
                ctl.op  = OP_INS;
                count_d = count_q + CNT_W'(1);
                if (pos_c == count_q) begin
                  back_d = in_din;
                end
              end
            end
            CMD_REMOVE: begin
              if (pos_c >= count_q) begin
                err_d = ERR_INDEX;
              end else begin
                ctl.op  = OP_DEL;
                count_d = count_q - CNT_W'(1);
                // removing the tail of a longer list: refetch the tail
                if ((pos_c == count_q - CNT_W'(1)) && (count_q >= CNT_W'(2))) begin
                  cnt_d      = count_q - CNT_W'(2);
                  cap_back_d = 1'b1;
                  state_d    = ST_LOAD;
                end
              end
            end
            CMD_READ_AT: begin
              if (pos_c >= count_q) begin
                err_d = ERR_INDEX;
              end else begin
                cnt_d      = pos_c;
                cap_dout_d = 1'b1;
                state_d    = ST_LOAD;
              end
            end
            CMD_READ_END: begin
              if (pos_c >= count_q) begin
                err_d = ERR_INDEX;
              end else begin
                cnt_d      = count_q - CNT_W'(1) - pos_c;
                cap_dout_d = 1'b1;
                state_d    = ST_LOAD;
              end
            end
            CMD_REVERSE: begin
              if (count_q > CNT_W'(1)) begin
                back_d  = front_w;
                cnt_d   = count_q;
                rev_d   = 1'b1;
                state_d = ST_LOAD;
              end
            end
            default: begin
              // unknown command: no change
            end
          endcase
        end
      end
      ST_LOAD: begin
        ctl.op = OP_LOAD;
        if (rev_q) begin
          state_d = ST_REV;
        end else if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        ctl.op = OP_SHIFT;
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_REV: begin
        ctl.op = OP_REV;
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          back_d    = res_back;
          m_valid_d = 1'b1;
          m_data_d  = {4'b0000, res_back_g, res_front_g, res_empty, count_q,
                       err_q, res_dout};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      cnt_q      <= '0;
      cap_dout_q <= 1'b0;
      cap_back_q <= 1'b0;
      rev_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      cnt_q      <= cnt_d;
      cap_dout_q <= cap_dout_d;
      cap_back_q <= cap_back_d;
      rev_q      <= rev_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    back_q   <= back_d;
    dout_q   <= dout_d;
    err_q    <= err_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  `ILE_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `ILE_ASSERT_NEXT(a_count_hold, !(s_axis_tvalid && s_axis_tready), $stable(count_q), "count moved")
  `ILE_ASSERT_IMPL(a_walk_cnt, state_q == ST_WALK || state_q == ST_REV, cnt_q != '0, "walk underflow")
  `ILE_ASSERT_IMPL(a_result_src, $rose(m_axis_tvalid), $past(state_q == ST_DONE), "stray result")

endmodule

`default_nettype wire
